FILE: hw/rtl/key_click_longpress_classifier_macros.svh
// Assertion macros for the key click / long-press classifier.
`ifndef KEY_CLICK_LONGPRESS_CLASSIFIER_MACROS_SVH
`define KEY_CLICK_LONGPRESS_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define KCLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define KCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KCLP_ASSERT_SAME(lbl, ante, cons, msg)
`define KCLP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/kclp_pkg.sv
// Shared types and constants of the key click / long-press classifier.
`default_nettype none

package kclp_pkg;

  // Slots fixed by the key_row and key_column field widths.
  localparam int ROW_W     = 2;
  localparam int COL_W     = 3;
  localparam int ROW_SLOTS = 1 << ROW_W;
  localparam int COL_SLOTS = 1 << COL_W;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 8;
  localparam int CMD_W  = 8;

  // Key (r,c) sits at bit KEY_BIT_STRIDE*c + ROW_TOP_BIT - r.
  localparam int KEY_BIT_STRIDE = 4;
  localparam int ROW_TOP_BIT    = 2;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd10;
  localparam logic [CNT_W-1:0] CNT_MAX         = 8'hFF;

  // Brightness command: base opcode ORed with a level.
  localparam logic [CMD_W-1:0] CMD_BASE    = 8'h80;
  localparam logic [CMD_W-1:0] BRIGHT_DIM  = 8'h07;
  localparam logic [CMD_W-1:0] BRIGHT_FULL = 8'h0F;

  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_RELEASE   = 2'd1,
    ST_CLICK     = 2'd2,
    ST_LONGPRESS = 2'd3
  } key_state_t;

  typedef struct packed {
    key_state_t       key_status;
    logic             multi_key;
    logic [CMD_W-1:0] display_command;
  } result_t;

  // Lane control from the top level.
  typedef struct packed {
    logic scan_en;
    logic pressed;
    logic query_hit;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kclp_ifs.sv
// Valid/ready channel interfaces: input items, results and configuration.
`default_nettype none

interface kclp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] scan_word;
  logic [1:0]  key_row;
  logic [2:0]  key_column;

  modport source (output valid, operation, scan_word, key_row, key_column, input ready);
  modport sink   (input valid, operation, scan_word, key_row, key_column, output ready);
endinterface

interface kclp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_status;
  logic       multi_key;
  logic [7:0] display_command;

  modport source (output valid, key_status, multi_key, display_command, input ready);
  modport sink   (input valid, key_status, multi_key, display_command, output ready);
endinterface

interface kclp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] long_press_threshold;

  modport source (output valid, long_press_threshold, input ready);
  modport sink   (input valid, long_press_threshold, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kclp_key_lane.sv
// One key: press counter, status state machine and read mark.
`default_nettype none

module kclp_key_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kclp_pkg::lane_ctrl_t               ctrl,
  input  logic [kclp_pkg::CNT_W-1:0]         threshold,
  output kclp_pkg::key_state_t               status
);
  import kclp_pkg::*;

  key_state_t       state_r, state_nxt, state_eff;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic             mark_r, mark_nxt, mark_clear;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RELEASE;
      cnt_r   <= '0;
      mark_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_comb begin
    // a read click/long press drops to none at the next scan
    mark_clear = mark_r && (state_r != ST_RELEASE);
    state_eff  = mark_clear ? ST_NONE : state_r;
    cnt_inc    = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 8'd1;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    mark_nxt   = mark_r;
    if (ctrl.scan_en) begin
      state_nxt = state_eff;
      if (mark_clear) mark_nxt = 1'b0;
      unique case (state_eff)
        ST_RELEASE: begin
          if (ctrl.pressed) begin
            cnt_nxt = cnt_inc;
          end else if (cnt_r != '0 && cnt_r < threshold) begin
            state_nxt = ST_CLICK;
          end
          if ((ctrl.pressed ? cnt_inc : cnt_r) >= threshold) state_nxt = ST_LONGPRESS;
        end
        ST_NONE: begin
          if (ctrl.pressed && cnt_r >= threshold) begin
            state_nxt = ST_LONGPRESS;
          end else begin
            state_nxt = ST_RELEASE;
            cnt_nxt   = '0;
          end
        end
        ST_CLICK, ST_LONGPRESS: begin
          state_nxt = state_eff;
        end
        default: state_nxt = state_eff;
      endcase
    end
    if (ctrl.query_hit) mark_nxt = 1'b1;
  end

  assign status = state_r;

endmodule

`default_nettype wire

FILE: hw/rtl/kclp_merge.sv
// Merge stage: picks the queried lane, flags multi-key scans, forms the result.
`default_nettype none

module kclp_merge (
  input  logic                               operation,
  input  logic [kclp_pkg::WORD_W-1:0]        scan_word,
  input  logic [kclp_pkg::ROW_W-1:0]         key_row,
  input  logic [kclp_pkg::COL_W-1:0]         key_column,
  input  kclp_pkg::key_state_t               grid [kclp_pkg::ROW_SLOTS][kclp_pkg::COL_SLOTS],
  output kclp_pkg::result_t                  result
);
  import kclp_pkg::*;

  logic multi;

  // more than one bit set: clearing the lowest set bit leaves something
  assign multi = (scan_word & (scan_word - 32'd1)) != '0;

  always_comb begin
    result = '0;
    if (operation == OP_QUERY) begin
      // slots outside the configured matrix read as none
      result.key_status = grid[key_row][key_column];
    end else begin
      result.key_status      = ST_NONE;
      result.multi_key       = multi;
      result.display_command = CMD_BASE | (multi ? BRIGHT_DIM : BRIGHT_FULL);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kclp_out_skid.sv
// Output register with a skid entry so input and output stall independently.
`default_nettype none

module kclp_out_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  kclp_pkg::result_t   result,
  input  logic                out_ready,
  output logic                out_valid,
  output kclp_pkg::result_t   out_data,
  output logic                skid_full
);
  import kclp_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      // output slot frees: skid entry first, else the new beat
      out_valid_nxt  = skid_valid_r || load;
      out_data_nxt   = skid_valid_r ? skid_data_r : result;
      skid_valid_nxt = 1'b0;
    end else if (load) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign skid_full = skid_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/key_click_longpress_classifier.sv
// Top level: key matrix click / long-press classifier with scan and query beats.
//
//  channel | dir | payload                                        | beat
//  --------+-----+------------------------------------------------+------------------
//  in_ch   | in  | operation, scan_word, key_row, key_column      | one scan or query
//  out_ch  | out | key_status, multi_key, display_command         | one result
//  cfg_ch  | in  | long_press_threshold                           | threshold write
//
//  All key lanes update in parallel on the accept edge, so a beat can follow every cycle
//  while in_ch.ready is high; its result is registered in the output register or the skid entry.
//  The output register plus one skid entry let in_ch accept while a result waits;
//  in_ch.ready drops only when both are full.
//  Synchronous active-low reset: every key to release, counts and read marks to
//  zero, threshold to 10. No clearing pass; ready rises right after reset.
`default_nettype none

`include "key_click_longpress_classifier_macros.svh"

module key_click_longpress_classifier #(
  parameter int KEY_ROWS    = 3,
  parameter int KEY_COLUMNS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  kclp_in_if.sink          in_ch,
  kclp_out_if.source       out_ch,
  kclp_cfg_if.sink         cfg_ch
);
  import kclp_pkg::*;

  logic             in_fire;
  logic             is_scan, is_query;
  logic [CNT_W-1:0] threshold_r;
  logic             skid_full;
  result_t          merged;
  result_t          out_data;
  key_state_t       grid [ROW_SLOTS][COL_SLOTS];

  // Threshold register; the user must write it only while the block is idle (not enforced here).
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      threshold_r <= cfg_ch.long_press_threshold;
    end
  end

  assign in_ch.ready = rst_n && !skid_full;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_scan     = in_fire && (in_ch.operation == OP_SCAN);
  assign is_query    = in_fire && (in_ch.operation == OP_QUERY);

  // Key lanes over the configured matrix; unused slots read as none.
  for (genvar r = 0; r < ROW_SLOTS; r++) begin : g_row
    for (genvar c = 0; c < COL_SLOTS; c++) begin : g_col
      if (r < KEY_ROWS && c < KEY_COLUMNS) begin : g_lane
        localparam int BitPos = KEY_BIT_STRIDE * c + ROW_TOP_BIT - r;
        lane_ctrl_t ctrl;
        logic       pressed;

        if (BitPos >= 0) begin : g_bit
          assign pressed = in_ch.scan_word[BitPos];
        end else begin : g_nobit
          // bit would fall below zero: key always reads released
          assign pressed = 1'b0;
        end

        assign ctrl.scan_en   = is_scan;
        assign ctrl.pressed   = pressed;
        assign ctrl.query_hit = is_query
                                && (in_ch.key_row == ROW_W'(r))
                                && (in_ch.key_column == COL_W'(c));

        kclp_key_lane u_lane (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctrl      (ctrl),
          .threshold (threshold_r),
          .status    (grid[r][c])
        );
      end else begin : g_empty
        assign grid[r][c] = ST_NONE;
      end
    end
  end

  kclp_merge u_merge (
    .operation  (in_ch.operation),
    .scan_word  (in_ch.scan_word),
    .key_row    (in_ch.key_row),
    .key_column (in_ch.key_column),
    .grid       (grid),
    .result     (merged)
  );

  kclp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .result    (merged),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign out_ch.key_status      = out_data.key_status;
  assign out_ch.multi_key       = out_data.multi_key;
  assign out_ch.display_command = out_data.display_command;

  // Checks
  `KCLP_ASSERT_SAME(a_skid_behind_out, skid_full, out_ch.valid, "skid entry held without output")
  `KCLP_ASSERT_NEXT(a_beat_gives_result, in_fire, out_ch.valid, "accepted beat left no result")
  `KCLP_ASSERT_NEXT(a_stall_fills_skid, in_fire && out_ch.valid && !out_ch.ready, skid_full, "stalled beat not parked in skid")
  `KCLP_ASSERT_NEXT(a_cfg_lands, cfg_ch.valid && cfg_ch.ready, threshold_r == $past(cfg_ch.long_press_threshold), "threshold write lost")

endmodule

`default_nettype wire
